// ===== src/range_target_select_average_defines.svh =====
// Assertion macros used by the port-level checker of the range averager.
`ifndef RANGE_TARGET_SELECT_AVERAGE_DEFINES_SVH
`define RANGE_TARGET_SELECT_AVERAGE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, muted in reset
`define RTSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, muted in reset
`define RTSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rtsa_pkg.sv =====
// Shared types, widths, register codes and reset values of the range averager.
package rtsa_pkg;

    // Sizing
    localparam int MAX_TARGETS  = 4;
    localparam int COUNT_BITS   = 16;
    localparam int SUM_BITS     = 32;
    localparam int DIST_BITS    = 15;
    localparam int STATUS_BITS  = 8;
    localparam int RANGE_BITS   = 16;
    localparam int TC_BITS      = 3;
    localparam int TIME_BITS    = 32;
    localparam int MASK_BITS    = 32;
    localparam int TO_BITS      = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int IDX_BITS     = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int STEP_BITS    = $clog2(SUM_BITS + 1);

    // Register reset values
    localparam logic [MASK_BITS-1:0] ACCEPT_MASK_RST = MASK_BITS'(4719345);
    localparam logic [DIST_BITS-1:0] MAX_RANGE_RST   = DIST_BITS'(5000);
    localparam logic [TO_BITS-1:0]   TIMEOUT_RST     = TO_BITS'(300);

    // Request codes
    localparam logic REQ_FRAME  = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ACCEPT_MASK = 2'd0,
        CFG_MAX_RANGE   = 2'd1,
        CFG_TIMEOUT     = 2'd2
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACCUM,
        ST_DIV,
        ST_PUSH
    } state_t;

    // Divider handshake with the sequencer
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic done;
    } div_rsp_t;

endpackage

// ===== src/rtsa_target_check.sv =====
// Qualification of one target: status accepted by mask and range inside (0, max).
module rtsa_target_check
(
    input  logic [rtsa_pkg::STATUS_BITS-1:0]       status,
    input  logic signed [rtsa_pkg::RANGE_BITS-1:0] target_range,
    input  logic [rtsa_pkg::MASK_BITS-1:0]         accept_mask,
    input  logic [rtsa_pkg::DIST_BITS-1:0]         max_range,
    output logic                                   hit
);

    logic status_ok;
    logic range_ok;

    // Codes above 31 never qualify
    assign status_ok = (status[rtsa_pkg::STATUS_BITS-1:5] == '0) && accept_mask[status[4:0]];

    // Strictly positive and strictly below the limit
    assign range_ok = !target_range[rtsa_pkg::RANGE_BITS-1]
                      && (target_range != '0)
                      && (target_range[rtsa_pkg::DIST_BITS-1:0] < max_range);

    assign hit = status_ok && range_ok;

endmodule

// ===== src/rtsa_divider.sv =====
// Restoring serial divider: one quotient bit per cycle for sum / count.
module rtsa_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rtsa_pkg::div_req_t                req,
    input  logic [rtsa_pkg::SUM_BITS-1:0]     dividend,
    input  logic [rtsa_pkg::COUNT_BITS-1:0]   divisor,
    output rtsa_pkg::div_rsp_t                rsp,
    output logic [rtsa_pkg::SUM_BITS-1:0]     quotient
);

    localparam int W = rtsa_pkg::COUNT_BITS;
    localparam int N = rtsa_pkg::SUM_BITS;

    logic                            busy_reg;
    logic                            done_reg;
    logic [rtsa_pkg::STEP_BITS-1:0]  step_reg;
    logic [W-1:0]                    rem_reg;
    logic [W-1:0]                    dvs_reg;
    logic [N-1:0]                    quo_reg;

    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] rem_next;
    logic         last_step;

    // One trial subtraction per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[N-1]};
        ge        = (shifted >= {1'b0, dvs_reg});
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = ge ? diff[W-1:0] : shifted[W-1:0];
        last_step = (step_reg == rtsa_pkg::STEP_BITS'(N - 1));
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + rtsa_pkg::STEP_BITS'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: quotient bits shift in where dividend bits shift out
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[N-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/range_target_select_average.sv =====
// Top level of the range averager: sequencer, accumulator, registers and output stage.
//
// Range averager. A measurement frame (req_type 0) is accepted when in_valid is high and
// in_stall low; the targets are then examined one per cycle by a single qualification
// unit, and the first qualifying range is added to the running sum and count. A frame
// with no targets goes straight back to idle; otherwise it passes through the scan state
// and, on a hit, the accumulate state. A report request (req_type 1) with readings stored
// runs the serial divider, one quotient bit per cycle over the 32-bit sum; with nothing
// stored it goes straight to the output stage. Each report yields one result transaction,
// held in an output register until out_stall is low; a report waits for that register to
// free up, and in_stall stays high while an item is being worked on. Configuration writes
// are always ready (cfg_ready is tied high) and must be issued only while no item is in
// flight.
module range_target_select_average
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    // Input channel
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    req_type,
    input  logic [rtsa_pkg::TC_BITS-1:0]            target_count,
    input  logic [rtsa_pkg::STATUS_BITS-1:0]        status_a,
    input  logic [rtsa_pkg::STATUS_BITS-1:0]        status_b,
    input  logic [rtsa_pkg::STATUS_BITS-1:0]        status_c,
    input  logic [rtsa_pkg::STATUS_BITS-1:0]        status_d,
    input  logic signed [rtsa_pkg::RANGE_BITS-1:0]  range_a,
    input  logic signed [rtsa_pkg::RANGE_BITS-1:0]  range_b,
    input  logic signed [rtsa_pkg::RANGE_BITS-1:0]  range_c,
    input  logic signed [rtsa_pkg::RANGE_BITS-1:0]  range_d,
    input  logic [rtsa_pkg::TIME_BITS-1:0]          now_ms,

    // Output channel
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [rtsa_pkg::DIST_BITS-1:0]          distance_mm,
    output logic                                    fresh,
    output logic                                    no_data,
    output logic [rtsa_pkg::TIME_BITS-1:0]          last_time_ms,

    // Configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [rtsa_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [rtsa_pkg::MASK_BITS-1:0]          cfg_data
);

    localparam int NT = rtsa_pkg::MAX_TARGETS;

    // Configuration registers
    logic [rtsa_pkg::MASK_BITS-1:0] accept_mask_reg;
    logic [rtsa_pkg::DIST_BITS-1:0] max_range_reg;
    logic [rtsa_pkg::TO_BITS-1:0]   timeout_reg;

    // Sequencer
    rtsa_pkg::state_t state_reg;
    rtsa_pkg::state_t state_next;
    logic [rtsa_pkg::IDX_BITS-1:0]  idx_reg;

    // Captured item
    logic                                  req_reg;
    logic [rtsa_pkg::TC_BITS-1:0]          scan_len_reg;
    logic [rtsa_pkg::STATUS_BITS-1:0]      status_reg [NT];
    logic signed [rtsa_pkg::RANGE_BITS-1:0] range_reg [NT];
    logic [rtsa_pkg::TIME_BITS-1:0]        now_reg;

    // Accumulator state
    logic [rtsa_pkg::SUM_BITS-1:0]   sum_reg;
    logic [rtsa_pkg::COUNT_BITS-1:0] count_reg;
    logic [rtsa_pkg::TIME_BITS-1:0]  last_report_reg;
    logic [rtsa_pkg::DIST_BITS-1:0]  pick_reg;
    logic [rtsa_pkg::DIST_BITS-1:0]  avg_reg;
    logic                            fresh_reg;

    // Output stage
    logic                            out_valid_reg;
    logic [rtsa_pkg::DIST_BITS-1:0]  distance_reg;
    logic                            fresh_out_reg;
    logic                            no_data_reg;
    logic [rtsa_pkg::TIME_BITS-1:0]  last_time_reg;

    // Combinational helpers
    logic                                   in_accept;
    logic                                   out_free;
    logic                                   out_load;
    logic [rtsa_pkg::STATUS_BITS-1:0]       in_status [4];
    logic signed [rtsa_pkg::RANGE_BITS-1:0] in_range  [4];
    logic [rtsa_pkg::TC_BITS-1:0]           scan_len_in;
    logic                                   hit;
    logic                                   scan_last;
    logic [rtsa_pkg::SUM_BITS:0]            sum_ext;
    logic                                   can_add;
    logic [rtsa_pkg::TIME_BITS-1:0]         gap;
    logic                                   late;
    rtsa_pkg::div_req_t                     div_req;
    rtsa_pkg::div_rsp_t                     div_rsp;
    logic [rtsa_pkg::SUM_BITS-1:0]          quotient;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Input target fields as a list
    assign in_status[0] = status_a;
    assign in_status[1] = status_b;
    assign in_status[2] = status_c;
    assign in_status[3] = status_d;
    assign in_range[0]  = range_a;
    assign in_range[1]  = range_b;
    assign in_range[2]  = range_c;
    assign in_range[3]  = range_d;

    // Only the first MAX_TARGETS targets are examined
    assign scan_len_in = (target_count > rtsa_pkg::TC_BITS'(NT))
                       ? rtsa_pkg::TC_BITS'(NT) : target_count;

    // Shared qualification unit, fed by the current scan index
    rtsa_target_check u_check
    (
        .status       (status_reg[idx_reg]),
        .target_range (range_reg[idx_reg]),
        .accept_mask  (accept_mask_reg),
        .max_range    (max_range_reg),
        .hit          (hit)
    );

    assign scan_last = ((rtsa_pkg::TC_BITS'(idx_reg) + rtsa_pkg::TC_BITS'(1)) >= scan_len_reg);

    // Saturation and sum overflow check
    assign sum_ext = (rtsa_pkg::SUM_BITS+1)'(sum_reg) + (rtsa_pkg::SUM_BITS+1)'(pick_reg);
    assign can_add = (count_reg != '1) && !sum_ext[rtsa_pkg::SUM_BITS];

    // Gap since last produced average, modulo 2^32
    assign gap  = now_reg - last_report_reg;
    assign late = (gap > rtsa_pkg::TIME_BITS'(timeout_reg));

    rtsa_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .rsp      (div_rsp),
        .quotient (quotient)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtsa_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type == rtsa_pkg::REQ_REPORT)
                    begin
                        state_next = (count_reg == '0) ? rtsa_pkg::ST_PUSH : rtsa_pkg::ST_DIV;
                    end
                    else if (scan_len_in != '0)
                    begin
                        state_next = rtsa_pkg::ST_SCAN;
                    end
                end
            end
            rtsa_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = rtsa_pkg::ST_ACCUM;
                end
                else if (scan_last)
                begin
                    state_next = rtsa_pkg::ST_IDLE;
                end
            end
            rtsa_pkg::ST_ACCUM:
            begin
                state_next = rtsa_pkg::ST_IDLE;
            end
            rtsa_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = rtsa_pkg::ST_PUSH;
                end
            end
            rtsa_pkg::ST_PUSH:
            begin
                if (out_free)
                begin
                    state_next = rtsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rtsa_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall      = (state_reg != rtsa_pkg::ST_IDLE);
        div_req.start = (state_reg == rtsa_pkg::ST_IDLE) && in_accept
                        && (req_type == rtsa_pkg::REQ_REPORT) && (count_reg != '0);
        out_load      = (state_reg == rtsa_pkg::ST_PUSH) && out_free;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rtsa_pkg::ST_IDLE;
            idx_reg         <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            last_report_reg <= '0;
            out_valid_reg   <= 1'b0;
            accept_mask_reg <= rtsa_pkg::ACCEPT_MASK_RST;
            max_range_reg   <= rtsa_pkg::MAX_RANGE_RST;
            timeout_reg     <= rtsa_pkg::TIMEOUT_RST;
        end
        else
        begin
            state_reg <= state_next;

            // Scan index
            if (in_accept)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == rtsa_pkg::ST_SCAN)
            begin
                idx_reg <= idx_reg + rtsa_pkg::IDX_BITS'(1);
            end

            // Accumulate one reading
            if ((state_reg == rtsa_pkg::ST_ACCUM) && can_add)
            begin
                sum_reg   <= sum_ext[rtsa_pkg::SUM_BITS-1:0];
                count_reg <= count_reg + rtsa_pkg::COUNT_BITS'(1);
            end

            // Report with readings: clear and stamp the time
            if ((state_reg == rtsa_pkg::ST_DIV) && div_rsp.done)
            begin
                sum_reg         <= '0;
                count_reg       <= '0;
                last_report_reg <= now_reg;
            end

            // Output register valid
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // Configuration writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rtsa_pkg::CFG_ACCEPT_MASK: accept_mask_reg <= cfg_data;
                    rtsa_pkg::CFG_MAX_RANGE:   max_range_reg   <= cfg_data[rtsa_pkg::DIST_BITS-1:0];
                    rtsa_pkg::CFG_TIMEOUT:     timeout_reg     <= cfg_data[rtsa_pkg::TO_BITS-1:0];
                    default:                   ;
                endcase
            end
        end
    end

    // Item capture and payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg      <= req_type;
            scan_len_reg <= scan_len_in;
            now_reg      <= now_ms;
            for (int i = 0; i < NT; i++)
            begin
                status_reg[i] <= in_status[i];
                range_reg[i]  <= in_range[i];
            end
            if (req_type == rtsa_pkg::REQ_REPORT)
            begin
                fresh_reg <= 1'b0;
            end
        end

        // Latch the chosen range
        if ((state_reg == rtsa_pkg::ST_SCAN) && hit)
        begin
            pick_reg <= range_reg[idx_reg][rtsa_pkg::DIST_BITS-1:0];
        end

        // Average is below 2^15 since every reading is
        if ((state_reg == rtsa_pkg::ST_DIV) && div_rsp.done)
        begin
            avg_reg   <= quotient[rtsa_pkg::DIST_BITS-1:0];
            fresh_reg <= 1'b1;
        end

        // Result transaction
        if (out_load)
        begin
            distance_reg  <= fresh_reg ? avg_reg : '0;
            fresh_out_reg <= fresh_reg;
            no_data_reg   <= !fresh_reg && late && (req_reg == rtsa_pkg::REQ_REPORT);
            last_time_reg <= last_report_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign distance_mm  = distance_reg;
    assign fresh        = fresh_out_reg;
    assign no_data      = no_data_reg;
    assign last_time_ms = last_time_reg;

endmodule

// ===== src/rtsa_checker.sv =====
// Port-level checker for the range averager, bound to the top level.
`include "range_target_select_average_defines.svh"

module rtsa_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic                                    req_type,
    input  logic [rtsa_pkg::TC_BITS-1:0]            target_count,
    input  logic [rtsa_pkg::STATUS_BITS-1:0]        status_a,
    input  logic [rtsa_pkg::STATUS_BITS-1:0]        status_b,
    input  logic [rtsa_pkg::STATUS_BITS-1:0]        status_c,
    input  logic [rtsa_pkg::STATUS_BITS-1:0]        status_d,
    input  logic signed [rtsa_pkg::RANGE_BITS-1:0]  range_a,
    input  logic signed [rtsa_pkg::RANGE_BITS-1:0]  range_b,
    input  logic signed [rtsa_pkg::RANGE_BITS-1:0]  range_c,
    input  logic signed [rtsa_pkg::RANGE_BITS-1:0]  range_d,
    input  logic [rtsa_pkg::TIME_BITS-1:0]          now_ms,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic [rtsa_pkg::DIST_BITS-1:0]          distance_mm,
    input  logic                                    fresh,
    input  logic                                    no_data,
    input  logic [rtsa_pkg::TIME_BITS-1:0]          last_time_ms,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [rtsa_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [rtsa_pkg::MASK_BITS-1:0]          cfg_data
);

    // A stalled result holds
    `RTSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(distance_mm) && $stable(fresh) && $stable(no_data) && $stable(last_time_ms), "stalled result changed")

    // A fresh average never carries the no-data flag
    `RTSA_ASSERT_NOW(a_fresh_excl, out_valid && fresh, !no_data, "fresh and no_data both set")

    // Without an average the distance reads zero
    `RTSA_ASSERT_NOW(a_stale_zero, out_valid && !fresh, distance_mm == '0, "stale result with nonzero distance")

    // A measurement frame accepted with the output empty yields no result
    `RTSA_ASSERT_NEXT(a_frame_silent, in_valid && !in_stall && (req_type == rtsa_pkg::REQ_FRAME) && !out_valid, !out_valid, "measurement frame produced a result")

endmodule

bind range_target_select_average rtsa_checker u_rtsa_checker (.*);

// ===== verif/range_target_select_average_checker.sv =====
// Scoreboard for the range averager: tracks its state, predicts every report and checks it.
module range_target_select_average_checker
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                req_type,
    input  logic [rtsa_pkg::TC_BITS-1:0]        target_count,
    input  logic [rtsa_pkg::STATUS_BITS-1:0]    status_a,
    input  logic [rtsa_pkg::STATUS_BITS-1:0]    status_b,
    input  logic [rtsa_pkg::STATUS_BITS-1:0]    status_c,
    input  logic [rtsa_pkg::STATUS_BITS-1:0]    status_d,
    input  logic [rtsa_pkg::RANGE_BITS-1:0]     range_a,
    input  logic [rtsa_pkg::RANGE_BITS-1:0]     range_b,
    input  logic [rtsa_pkg::RANGE_BITS-1:0]     range_c,
    input  logic [rtsa_pkg::RANGE_BITS-1:0]     range_d,
    input  logic [rtsa_pkg::TIME_BITS-1:0]      now_ms,

    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [rtsa_pkg::DIST_BITS-1:0]      distance_mm,
    input  logic                                fresh,
    input  logic                                no_data,
    input  logic [rtsa_pkg::TIME_BITS-1:0]      last_time_ms,

    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [rtsa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [rtsa_pkg::MASK_BITS-1:0]      cfg_data,

    output int                                  errors,
    output int                                  n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [rtsa_pkg::DIST_BITS-1:0] distance;
        logic                           fresh;
        logic                           no_data;
        logic [rtsa_pkg::TIME_BITS-1:0] last_time;
    } report_t;

    // Reports predicted but not yet seen on the output channel
    report_t reports_due[$];

    // Register copies
    logic [rtsa_pkg::MASK_BITS-1:0]  accept_mask;
    logic [rtsa_pkg::DIST_BITS-1:0]  range_limit;
    logic [rtsa_pkg::TO_BITS-1:0]    gap_limit;

    // Accumulator copies
    logic [rtsa_pkg::SUM_BITS-1:0]   sum_mm;
    logic [rtsa_pkg::COUNT_BITS-1:0] n_readings;
    logic [rtsa_pkg::TIME_BITS-1:0]  last_avg_ms;

    // First target, in order, with an accepted status and a range in (0, range_limit)
    function automatic logic select_target(
        input  logic [rtsa_pkg::TC_BITS-1:0]                                 tc,
        input  logic [rtsa_pkg::MAX_TARGETS-1:0][rtsa_pkg::STATUS_BITS-1:0]  st,
        input  logic [rtsa_pkg::MAX_TARGETS-1:0][rtsa_pkg::RANGE_BITS-1:0]   rg,
        output logic [rtsa_pkg::RANGE_BITS-1:0]                              chosen
    );
        int n;
        n = (tc > rtsa_pkg::MAX_TARGETS) ? rtsa_pkg::MAX_TARGETS : int'(tc);
        chosen = '0;
        for (int i = 0; i < n; i++)
        begin
            if (st[i] < 32 && accept_mask[st[i][4:0]] && rg[i] != '0
                && !rg[i][rtsa_pkg::RANGE_BITS-1]
                && rg[i] < rtsa_pkg::RANGE_BITS'(range_limit))
            begin
                chosen = rg[i];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        report_t                         want;
        logic [rtsa_pkg::RANGE_BITS-1:0] pick;
        logic [rtsa_pkg::SUM_BITS:0]     grown;
        logic [rtsa_pkg::TIME_BITS-1:0]  gap;
        if (!rst_n)
        begin
            reports_due.delete();
            accept_mask = rtsa_pkg::ACCEPT_MASK_RST;
            range_limit = rtsa_pkg::MAX_RANGE_RST;
            gap_limit   = rtsa_pkg::TIMEOUT_RST;
            sum_mm      = '0;
            n_readings  = '0;
            last_avg_ms = '0;
            errors      = 0;
            n_pending  <= 0;
        end
        else
        begin
            // Result transaction: compare with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected report, expected none, actual %0d/%0b/%0b/%0d",
                             $time, distance_mm, fresh, no_data, last_time_ms);
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("distance_mm", 32'(want.distance), 32'(distance_mm));
                    check_field("fresh", 32'(want.fresh), 32'(fresh));
                    check_field("no_data", 32'(want.no_data), 32'(no_data));
                    check_field("last_time_ms", want.last_time, last_time_ms);
                end
            end

            // Register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rtsa_pkg::CFG_ACCEPT_MASK: accept_mask = cfg_data;
                    rtsa_pkg::CFG_MAX_RANGE:   range_limit = cfg_data[rtsa_pkg::DIST_BITS-1:0];
                    rtsa_pkg::CFG_TIMEOUT:     gap_limit   = cfg_data[rtsa_pkg::TO_BITS-1:0];
                    default:                   ;
                endcase
            end

            // Input transaction: update the accumulator or predict a report
            if (in_valid && !in_stall)
            begin
                if (req_type == rtsa_pkg::REQ_FRAME)
                begin
                    if (select_target(target_count, {status_d, status_c, status_b, status_a},
                                      {range_d, range_c, range_b, range_a}, pick))
                    begin
                        grown = sum_mm + pick;
                        // count saturated or sum would carry out: frame dropped
                        if (n_readings != '1 && !grown[rtsa_pkg::SUM_BITS])
                        begin
                            sum_mm = grown[rtsa_pkg::SUM_BITS-1:0];
                            n_readings++;
                        end
                    end
                end
                else
                begin
                    if (n_readings != '0)
                    begin
                        want.distance  = rtsa_pkg::DIST_BITS'(sum_mm / n_readings);
                        want.fresh     = 1'b1;
                        want.no_data   = 1'b0;
                        want.last_time = now_ms;
                        sum_mm         = '0;
                        n_readings     = '0;
                        last_avg_ms    = now_ms;
                    end
                    else
                    begin
                        gap            = now_ms - last_avg_ms;
                        want.distance  = '0;
                        want.fresh     = 1'b0;
                        want.no_data   = (gap > rtsa_pkg::TIME_BITS'(gap_limit));
                        want.last_time = last_avg_ms;
                    end
                    reports_due.push_back(want);
                end
            end
            n_pending <= reports_due.size();
        end
    end

endmodule

// ===== verif/range_target_select_average_tb.sv =====
// Top of the range averager testbench: clock, reset, stimulus, output stalls and verdict.
module range_target_select_average_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int SETTLE_CYCLES   = 50;
    localparam int RAND_PHASES     = 6;
    localparam int PHASE_ITEMS     = 305;
    localparam logic [rtsa_pkg::CFG_IDX_BITS-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic                                                         req;
        logic [rtsa_pkg::TC_BITS-1:0]                                 tc;
        logic [rtsa_pkg::MAX_TARGETS-1:0][rtsa_pkg::STATUS_BITS-1:0]  st;
        logic [rtsa_pkg::MAX_TARGETS-1:0][rtsa_pkg::RANGE_BITS-1:0]   rg;
        logic [rtsa_pkg::TIME_BITS-1:0]                               now;
    } txn_t;

    logic                                    clk;
    logic                                    rst_n;
    logic                                    in_valid;
    logic                                    in_stall;
    logic                                    req_type;
    logic [rtsa_pkg::TC_BITS-1:0]            target_count;
    logic [rtsa_pkg::STATUS_BITS-1:0]        status_a, status_b, status_c, status_d;
    logic signed [rtsa_pkg::RANGE_BITS-1:0]  range_a, range_b, range_c, range_d;
    logic [rtsa_pkg::TIME_BITS-1:0]          now_ms;
    logic                                    out_valid;
    logic                                    out_stall;
    logic [rtsa_pkg::DIST_BITS-1:0]          distance_mm;
    logic                                    fresh;
    logic                                    no_data;
    logic [rtsa_pkg::TIME_BITS-1:0]          last_time_ms;
    logic                                    cfg_valid;
    logic                                    cfg_ready;
    logic [rtsa_pkg::CFG_IDX_BITS-1:0]       cfg_index;
    logic [rtsa_pkg::MASK_BITS-1:0]          cfg_data;

    int                                      errors;
    int                                      n_pending;
    int                                      idle_cycles;
    logic                                    hold_request;

    // Stimulus-side view of the registers, used to shape random items
    logic [rtsa_pkg::MASK_BITS-1:0]          cur_mask;
    logic [rtsa_pkg::DIST_BITS-1:0]          cur_max;
    logic [rtsa_pkg::TO_BITS-1:0]            cur_timeout;
    logic [rtsa_pkg::TIME_BITS-1:0]          clock_ms;
    int                                      burst_left;

    range_target_select_average dut (.*);

    range_target_select_average_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: ends the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: stall modes that change every so often, plus one long hold-off on request
    initial
    begin : receiver
        int   hold_left;
        int   mode;
        int   mode_left;
        int   tick;
        logic hold_done;
        logic stall_next;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(3, 0);
                mode_left = $urandom_range(240, 16);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else
            begin
                case (mode)
                    0:       stall_next = 1'b0;
                    1:       stall_next = ($urandom_range(2, 0) == 0);
                    2:       stall_next = (tick % 5 < 2);
                    default: stall_next = ($urandom_range(3, 0) != 0);
                endcase
            end
            out_stall <= stall_next;
        end
    end

    function automatic txn_t frame(input logic [rtsa_pkg::TC_BITS-1:0] tc,
                                   input logic [7:0] s0, input logic [15:0] r0,
                                   input logic [7:0] s1, input logic [15:0] r1,
                                   input logic [7:0] s2, input logic [15:0] r2,
                                   input logic [7:0] s3, input logic [15:0] r3);
        txn_t t;
        t.req = rtsa_pkg::REQ_FRAME;
        t.tc  = tc;
        t.st  = {s3, s2, s1, s0};
        t.rg  = {r3, r2, r1, r0};
        t.now = $urandom();
        return t;
    endfunction

    function automatic txn_t report(input logic [rtsa_pkg::TIME_BITS-1:0] now);
        txn_t t;
        t     = txn_t'({$urandom(), $urandom(), $urandom(), $urandom()});
        t.req = rtsa_pkg::REQ_REPORT;
        t.now = now;
        return t;
    endfunction

    // Mostly a status the mask accepts, otherwise any byte
    function automatic logic [rtsa_pkg::STATUS_BITS-1:0] pick_status();
        int c;
        for (int k = 0; k < 8; k++)
        begin
            c = $urandom_range(31, 0);
            if (cur_mask[c])
                return rtsa_pkg::STATUS_BITS'(c);
        end
        return rtsa_pkg::STATUS_BITS'($urandom());
    endfunction

    function automatic txn_t rand_txn();
        txn_t t;
        int   kind;
        t    = txn_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        kind = $urandom_range(99, 0);
        if (kind < 13)
        begin
            t.req = rtsa_pkg::REQ_REPORT;
            case ($urandom_range(9, 0))
                0:       clock_ms = $urandom();
                1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(int'(cur_timeout), 0);
                default: clock_ms = clock_ms + $urandom_range(2 * int'(cur_timeout) + 2, 0);
            endcase
            t.now = clock_ms;
        end
        else if (kind < 83)
        begin
            // well-formed frame: plausible statuses and in-window ranges
            t.req = rtsa_pkg::REQ_FRAME;
            t.tc  = rtsa_pkg::TC_BITS'($urandom_range(rtsa_pkg::MAX_TARGETS, 1));
            for (int i = 0; i < rtsa_pkg::MAX_TARGETS; i++)
            begin
                if ($urandom_range(2, 0) != 0)
                    t.st[i] = pick_status();
                if ($urandom_range(3, 0) != 0 && cur_max > 1)
                    t.rg[i] = rtsa_pkg::RANGE_BITS'($urandom_range(int'(cur_max) - 1, 1));
            end
        end
        else
            t.req = rtsa_pkg::REQ_FRAME;
        return t;
    endfunction

    // Offer one item, with an occasional gap before it, and wait until it is taken
    task automatic send(input txn_t t, input logic no_gaps);
        int gap;
        if (!no_gaps)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(($urandom_range(3, 0) == 0) ? 64 : 12, 1);
                gap = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        in_valid     <= 1'b1;
        req_type     <= t.req;
        target_count <= t.tc;
        status_a     <= t.st[0];
        status_b     <= t.st[1];
        status_c     <= t.st[2];
        status_d     <= t.st[3];
        range_a      <= t.rg[0];
        range_b      <= t.rg[1];
        range_c      <= t.rg[2];
        range_d      <= t.rg[3];
        now_ms       <= t.now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stop offering, wait for every report, then let the block go quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers in a rotated order, optionally poking the unused index
    task automatic configure(input logic [31:0] mask_w, input logic [31:0] max_w,
                             input logic [31:0] to_w, input logic poke_unmapped);
        rtsa_pkg::cfg_reg_t                order [3];
        logic [rtsa_pkg::CFG_IDX_BITS-1:0] idx_w;
        logic [31:0]                       data_w;
        int                                first;
        order = '{rtsa_pkg::CFG_ACCEPT_MASK, rtsa_pkg::CFG_MAX_RANGE, rtsa_pkg::CFG_TIMEOUT};
        first = $urandom_range(2, 0);
        for (int k = 0; k < 4; k++)
        begin
            if (k == 3)
            begin
                if (!poke_unmapped)
                    break;
                idx_w = CFG_UNMAPPED;
            end
            else
                idx_w = order[(first + k) % 3];
            case (idx_w)
                rtsa_pkg::CFG_ACCEPT_MASK: data_w = mask_w;
                rtsa_pkg::CFG_MAX_RANGE:   data_w = max_w;
                rtsa_pkg::CFG_TIMEOUT:     data_w = to_w;
                default:                   data_w = $urandom();
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx_w;
            cfg_data  <= data_w;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid   <= 1'b0;
        cur_mask     = mask_w;
        cur_max      = max_w[rtsa_pkg::DIST_BITS-1:0];
        cur_timeout  = to_w[rtsa_pkg::TO_BITS-1:0];
    endtask

    initial
    begin : stimulus
        logic [31:0]                    mask_w;
        logic [31:0]                    max_w;
        logic [31:0]                    to_w;
        logic [rtsa_pkg::TIME_BITS-1:0] wrap_ms;
        in_valid     <= 1'b0;
        req_type     <= rtsa_pkg::REQ_FRAME;
        target_count <= '0;
        status_a     <= '0;
        status_b     <= '0;
        status_c     <= '0;
        status_d     <= '0;
        range_a      <= '0;
        range_b      <= '0;
        range_c      <= '0;
        range_d      <= '0;
        now_ms       <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= rtsa_pkg::CFG_ACCEPT_MASK;
        cfg_data     <= '0;
        hold_request <= 1'b0;
        rst_n        <= 1'b0;
        cur_mask     = rtsa_pkg::ACCEPT_MASK_RST;
        cur_max      = rtsa_pkg::MAX_RANGE_RST;
        cur_timeout  = rtsa_pkg::TIMEOUT_RST;
        clock_ms     = '0;
        burst_left   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: timeout edges, target selection rules, average, time wrap
        send(report(32'd0), 1'b0);
        send(report(32'd301), 1'b0);
        send(report(32'd300), 1'b0);
        send(frame(3'd0, 8'd0, 16'd100, 8'd0, 16'd100, 8'd0, 16'd100, 8'd0, 16'd100), 1'b0);
        // too many targets: rejected status, status above 31, zero range, then accepted
        send(frame(3'd7, 8'd1, 16'd10, 8'd255, 16'd20, 8'd9, 16'd0, 8'd22, 16'd4999), 1'b0);
        send(frame(3'd4, 8'd0, 16'hFFFF, 8'd19, 16'd5000, 8'd4, 16'd1, 8'd5, 16'd7), 1'b0);
        send(frame(3'd1, 8'd32, 16'd100, 8'd0, 16'd200, 8'd0, 16'd300, 8'd0, 16'd400), 1'b0);
        send(frame(3'd5, 8'd7, 16'h7FFF, 8'd23, 16'd9, 8'd6, 16'h8000, 8'd5, 16'd2500), 1'b0);
        send(report(32'd1000), 1'b0);
        send(report(32'd999), 1'b0);
        drain();

        // Widest window and zero timeout, then reports near the top of the time range
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0000, 1'b1);
        send(frame(3'd2, 8'd31, 16'h7FFF, 8'd31, 16'h7FFE, 8'd0, 16'd1, 8'd0, 16'd1), 1'b0);
        send(report(32'd5), 1'b0);
        send(report(32'd5), 1'b0);
        send(report(32'd6), 1'b0);
        send(frame(3'd1, 8'd0, 16'h7FFE, 8'd0, 16'd0, 8'd0, 16'd0, 8'd0, 16'd0), 1'b1);
        send(frame(3'd1, 8'd0, 16'h7FFD, 8'd0, 16'd0, 8'd0, 16'd0, 8'd0, 16'd0), 1'b1);
        wrap_ms = 32'hFFFF_FFF0;
        send(report(wrap_ms), 1'b0);
        send(report(32'h0000_0010), 1'b0);
        drain();

        // Nothing accepted by mask; max range truncates to zero; longest timeout
        configure(32'h0000_0000, 32'h0001_8000, 32'h7777_FFFF, 1'b0);
        send(frame(3'd4, 8'd0, 16'd10, 8'd4, 16'd20, 8'd9, 16'd30, 8'd22, 16'd40), 1'b0);
        send(report(wrap_ms + 32'd65535), 1'b0);
        send(report(wrap_ms + 32'd65536), 1'b0);
        drain();
        configure(32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_FFFF, 1'b1);
        send(frame(3'd4, 8'd0, 16'd1, 8'd1, 16'd2, 8'd2, 16'd3, 8'd3, 16'd4), 1'b0);
        send(report($urandom()), 1'b0);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case ($urandom_range(4, 0))
                0:       mask_w = rtsa_pkg::ACCEPT_MASK_RST;
                1:       mask_w = '1;
                2:       mask_w = 32'h1 << $urandom_range(31, 0);
                default: mask_w = $urandom();
            endcase
            max_w = $urandom();
            case ($urandom_range(3, 0))
                0:       max_w[rtsa_pkg::DIST_BITS-1:0] = rtsa_pkg::MAX_RANGE_RST;
                1:       max_w[rtsa_pkg::DIST_BITS-1:0] =
                             rtsa_pkg::DIST_BITS'($urandom_range(64, 1));
                2:       max_w[rtsa_pkg::DIST_BITS-1:0] = '1;
                default: max_w[rtsa_pkg::DIST_BITS-1:0] =
                             rtsa_pkg::DIST_BITS'($urandom_range(32767, 1));
            endcase
            to_w = $urandom();
            case ($urandom_range(3, 0))
                0:       to_w[rtsa_pkg::TO_BITS-1:0] = rtsa_pkg::TO_BITS'($urandom_range(40, 0));
                1:       to_w[rtsa_pkg::TO_BITS-1:0] = rtsa_pkg::TIMEOUT_RST;
                2:       to_w[rtsa_pkg::TO_BITS-1:0] = '1;
                default: ;
            endcase
            configure(mask_w, max_w, to_w, $urandom_range(1, 0));
            // long output hold-off while items keep coming, so the block backs up
            if (p == 0)
                hold_request <= 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send(rand_txn(), 1'b0);
            drain();
        end

        if (errors == 0 && n_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== range_target_select_average.f =====
+incdir+src
src/rtsa_pkg.sv
src/rtsa_target_check.sv
src/rtsa_divider.sv
src/range_target_select_average.sv
src/rtsa_checker.sv
verif/range_target_select_average_checker.sv
verif/range_target_select_average_tb.sv
